// File: design/ptw_pkg.sv
// Package for the four-level page table walker: payload types, codes and the microcode ROM.
`default_nettype none

package ptw_pkg;

	// Input item and result item as they travel on the ports.
	typedef struct packed {
		logic [1:0]  opcode;
		logic [55:0] root;
		logic [63:0] vaddr;
		logic [63:0] paddr;
		logic [2:0]  prot;
		logic [63:0] reply_data;
	} in_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [55:0] address;
		logic [63:0] write_data;
		logic [55:0] lookup_frame;
		logic [2:0]  status;
		logic        last;
	} out_t;

	// Input opcodes.
	localparam logic [1:0] OPC_LOOKUP = 2'd0;
	localparam logic [1:0] OPC_MAP    = 2'd1;
	localparam logic [1:0] OPC_READ   = 2'd2;
	localparam logic [1:0] OPC_FRAME  = 2'd3;

	// Result kinds.
	localparam logic [2:0] K_READ  = 3'd0;
	localparam logic [2:0] K_WRITE = 3'd1;
	localparam logic [2:0] K_CLEAR = 3'd2;
	localparam logic [2:0] K_ALLOC = 3'd3;
	localparam logic [2:0] K_DONE  = 3'd4;

	// Completion status codes.
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_NOFRAME  = 3'd1;
	localparam logic [2:0] ST_BADV     = 3'd2;
	localparam logic [2:0] ST_BADP     = 3'd3;
	localparam logic [2:0] ST_MAPPED   = 3'd4;
	localparam logic [2:0] ST_NOTUSER  = 3'd5;
	localparam logic [2:0] ST_UNEXPECT = 3'd6;

	// Address field constants.
	localparam logic [63:0] BAD_VADDR_MASK = 64'hFFFF_0000_0000_0FFF;
	localparam logic [2:0]  LINK_BITS      = 3'h7;
	localparam int          TABLE_ENTRIES  = 512;
	localparam int          IDX_W          = $clog2(TABLE_ENTRIES);

	// Microcode program addresses.
	localparam int UA_W = 4;
	localparam logic [UA_W-1:0] UA_UNEXP    = 4'd0;
	localparam logic [UA_W-1:0] UA_BADV     = 4'd1;
	localparam logic [UA_W-1:0] UA_BADP     = 4'd2;
	localparam logic [UA_W-1:0] UA_START    = 4'd3;
	localparam logic [UA_W-1:0] UA_ABSENT   = 4'd4;
	localparam logic [UA_W-1:0] UA_LEAF     = 4'd5;
	localparam logic [UA_W-1:0] UA_NOTUSER  = 4'd6;
	localparam logic [UA_W-1:0] UA_DESCEND  = 4'd7;
	localparam logic [UA_W-1:0] UA_ALLOC    = 4'd8;
	localparam logic [UA_W-1:0] UA_MAPPED   = 4'd9;
	localparam logic [UA_W-1:0] UA_LWRITE   = 4'd10;
	localparam logic [UA_W-1:0] UA_LDONE    = 4'd11;
	localparam logic [UA_W-1:0] UA_NOFRAME  = 4'd12;
	localparam logic [UA_W-1:0] UA_GCLEAR   = 4'd13;
	localparam logic [UA_W-1:0] UA_GLINK    = 4'd14;

	// Address source of a result.
	typedef enum logic [1:0] {
		A_ZERO,
		A_NEXT,
		A_ENTRY,
		A_FRAME
	} asel_t;

	// Write data source of a result.
	typedef enum logic [1:0] {
		W_ZERO,
		W_LEAF,
		W_LINK
	} wsel_t;

	// Walk state update made by a step.
	typedef enum logic [2:0] {
		ACT_NONE,
		ACT_START,
		ACT_DESCEND,
		ACT_AWAIT,
		ACT_IDLE
	} act_t;

	// One control word: the result it emits, the state update and the next step.
	typedef struct packed {
		logic [2:0]      kind;
		asel_t           asel;
		wsel_t           wsel;
		logic            frame_en;
		logic [2:0]      status;
		act_t            act;
		logic            last;
		logic [UA_W-1:0] nxt;
	} uword_t;

	// The microcode program. Each step emits one result.
	function automatic uword_t ucode_rom(input logic [UA_W-1:0] ua);
		uword_t w;
		unique case (ua)
			UA_UNEXP:   w = '{K_DONE,  A_ZERO,  W_ZERO, 1'b0, ST_UNEXPECT, ACT_NONE,    1'b1, UA_UNEXP};
			UA_BADV:    w = '{K_DONE,  A_ZERO,  W_ZERO, 1'b0, ST_BADV,     ACT_NONE,    1'b1, UA_UNEXP};
			UA_BADP:    w = '{K_DONE,  A_ZERO,  W_ZERO, 1'b0, ST_BADP,     ACT_NONE,    1'b1, UA_UNEXP};
			UA_START:   w = '{K_READ,  A_NEXT,  W_ZERO, 1'b0, ST_OK,       ACT_START,   1'b1, UA_UNEXP};
			UA_ABSENT:  w = '{K_DONE,  A_ZERO,  W_ZERO, 1'b0, ST_OK,       ACT_IDLE,    1'b1, UA_UNEXP};
			UA_LEAF:    w = '{K_DONE,  A_ZERO,  W_ZERO, 1'b1, ST_OK,       ACT_IDLE,    1'b1, UA_UNEXP};
			UA_NOTUSER: w = '{K_DONE,  A_ZERO,  W_ZERO, 1'b0, ST_NOTUSER,  ACT_IDLE,    1'b1, UA_UNEXP};
			UA_DESCEND: w = '{K_READ,  A_NEXT,  W_ZERO, 1'b0, ST_OK,       ACT_DESCEND, 1'b1, UA_UNEXP};
			UA_ALLOC:   w = '{K_ALLOC, A_ZERO,  W_ZERO, 1'b0, ST_OK,       ACT_AWAIT,   1'b1, UA_UNEXP};
			UA_MAPPED:  w = '{K_DONE,  A_ZERO,  W_ZERO, 1'b0, ST_MAPPED,   ACT_IDLE,    1'b1, UA_UNEXP};
			UA_LWRITE:  w = '{K_WRITE, A_ENTRY, W_LEAF, 1'b0, ST_OK,       ACT_NONE,    1'b0, UA_LDONE};
			UA_LDONE:   w = '{K_DONE,  A_ZERO,  W_ZERO, 1'b0, ST_OK,       ACT_IDLE,    1'b1, UA_UNEXP};
			UA_NOFRAME: w = '{K_DONE,  A_ZERO,  W_ZERO, 1'b0, ST_NOFRAME,  ACT_IDLE,    1'b1, UA_UNEXP};
			UA_GCLEAR:  w = '{K_CLEAR, A_FRAME, W_ZERO, 1'b0, ST_OK,       ACT_NONE,    1'b0, UA_GLINK};
			UA_GLINK:   w = '{K_WRITE, A_ENTRY, W_LINK, 1'b0, ST_OK,       ACT_NONE,    1'b0, UA_DESCEND};
			default:    w = '{K_DONE,  A_ZERO,  W_ZERO, 1'b0, ST_UNEXPECT, ACT_NONE,    1'b1, UA_UNEXP};
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

// File: design/four_level_page_table_walker_top.sv
// Top level of the four-level page table walker: microcoded sequencer and walk datapath.
//
//  Channel   Ports                        Transfer
//  -------   --------------------------   ------------------------------------------
//  command   start, busy, cmd             at a rising edge with start high, busy low
//  result    result_valid, result         every edge that ends a cycle with strobe high
//
// An accepted item dispatches to a short microcode routine; each step of it emits one
// result, so the block takes no new item until the dispatch and every step of it are
// done. Results leave through an output register in the cycle after their step. The
// result side cannot stall. Reset clears the walk state to idle at once.
`default_nettype none

module four_level_page_table_walker_top
	import ptw_pkg::*;
(
	input  wire  logic clk,
	input  wire  logic arst_n,
	input  wire  logic start,
	output logic       busy,
	input  wire  in_t  cmd,
	output logic       result_valid,
	output out_t       result
);

	typedef enum logic [1:0] {
		OP_IDLE,
		OP_LOOKUP,
		OP_MAP
	} oper_t;

	oper_t            operation_q;
	logic [1:0]       level_q;
	logic             awaiting_q;
	logic [47:0]      saved_vaddr_q;
	logic [63:0]      saved_paddr_q;
	logic [2:0]       saved_prot_q;
	logic [55:0]      entry_address_q;
	in_t              item_q;
	logic             running_q;
	logic [UA_W-1:0]  upc_q;
	logic             valid_q;
	out_t             result_q;

	logic             accept;
	logic [UA_W-1:0]  dispatch;
	uword_t           uw;
	logic [47:0]      idx_vaddr;
	logic [1:0]       idx_level;
	logic [IDX_W-1:0] idx;
	logic [55:0]      base;
	logic [55:0]      next_entry;
	logic [55:0]      data_frame;
	logic [63:0]      leaf_entry;
	out_t             res_d;

	assign accept = start && !running_q;
	assign busy = running_q;
	assign result_valid = valid_q;
	assign result = result_q;

	// Dispatch: pick the routine from the incoming item and the current walk state.
	always_comb begin
		dispatch = UA_UNEXP;
		unique case (cmd.opcode)
			OPC_LOOKUP, OPC_MAP: begin
				priority if (operation_q != OP_IDLE) begin
					dispatch = UA_UNEXP;
				end else if ((cmd.vaddr & BAD_VADDR_MASK) != '0) begin
					dispatch = UA_BADV;
				end else if (cmd.opcode == OPC_MAP && cmd.paddr[11:0] != '0) begin
					dispatch = UA_BADP;
				end else begin
					dispatch = UA_START;
				end
			end
			OPC_READ: begin
				priority if (operation_q == OP_LOOKUP) begin
					priority if (!cmd.reply_data[0]) begin
						dispatch = UA_ABSENT;
					end else if (level_q == 2'd3) begin
						dispatch = UA_LEAF;
					end else if (!cmd.reply_data[2]) begin
						dispatch = UA_NOTUSER;
					end else begin
						dispatch = UA_DESCEND;
					end
				end else if (operation_q == OP_MAP && !awaiting_q) begin
					priority if (level_q != 2'd3) begin
						dispatch = cmd.reply_data[0] ? UA_DESCEND : UA_ALLOC;
					end else if (cmd.reply_data[0] && saved_paddr_q != '0) begin
						dispatch = UA_MAPPED;
					end else begin
						dispatch = UA_LWRITE;
					end
				end else begin
					dispatch = UA_UNEXP;
				end
			end
			OPC_FRAME: begin
				priority if (operation_q == OP_MAP && awaiting_q) begin
					dispatch = (cmd.reply_data == '0) ? UA_NOFRAME : UA_GCLEAR;
				end else begin
					dispatch = UA_UNEXP;
				end
			end
			default: dispatch = UA_UNEXP;
		endcase
	end

	// Current control word.
	assign uw = ucode_rom(upc_q);

	// Next entry address: table base plus eight times the index for the target level.
	assign idx_vaddr  = (uw.act == ACT_START) ? item_q.vaddr[47:0] : saved_vaddr_q;
	assign idx_level  = (uw.act == ACT_START) ? 2'd0 : level_q + 2'd1;
	assign data_frame = {item_q.reply_data[55:12], 12'h000};
	assign base       = (uw.act == ACT_START) ? item_q.root : data_frame;

	always_comb begin
		unique case (idx_level)
			2'd0:    idx = idx_vaddr[47:39];
			2'd1:    idx = idx_vaddr[38:30];
			2'd2:    idx = idx_vaddr[29:21];
			2'd3:    idx = idx_vaddr[20:12];
			default: idx = idx_vaddr[47:39];
		endcase
	end

	assign next_entry = base + {44'h0, idx, 3'b000};

	// Leaf entry built from the saved page and permission bits.
	always_comb begin
		leaf_entry = '0;
		if (saved_paddr_q != '0) begin
			leaf_entry = saved_paddr_q | 64'h1;
			if (saved_prot_q[1]) begin
				leaf_entry[1] = 1'b1;
			end
			if (!saved_prot_q[2]) begin
				leaf_entry[63] = 1'b1;
			end
			if (saved_prot_q != '0) begin
				leaf_entry[2] = 1'b1;
			end
		end
	end

	// Result of the current step.
	always_comb begin
		res_d = '0;
		res_d.kind = uw.kind;
		res_d.status = uw.status;
		res_d.last = uw.last;
		res_d.lookup_frame = uw.frame_en ? data_frame : '0;
		unique case (uw.asel)
			A_ZERO:  res_d.address = '0;
			A_NEXT:  res_d.address = next_entry;
			A_ENTRY: res_d.address = entry_address_q;
			A_FRAME: res_d.address = item_q.reply_data[55:0];
			default: res_d.address = '0;
		endcase
		unique case (uw.wsel)
			W_ZERO:  res_d.write_data = '0;
			W_LEAF:  res_d.write_data = leaf_entry;
			W_LINK:  res_d.write_data = {item_q.reply_data[63:3], LINK_BITS};
			default: res_d.write_data = '0;
		endcase
	end

	// Sequencer, walk state and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			operation_q     <= OP_IDLE;
			level_q         <= '0;
			awaiting_q      <= 1'b0;
			saved_vaddr_q   <= '0;
			saved_paddr_q   <= '0;
			saved_prot_q    <= '0;
			entry_address_q <= '0;
			item_q          <= '0;
			running_q       <= 1'b0;
			upc_q           <= UA_UNEXP;
			valid_q         <= 1'b0;
			result_q        <= '0;
		end else begin
			valid_q <= 1'b0;
			if (accept) begin
				item_q    <= cmd;
				upc_q     <= dispatch;
				running_q <= 1'b1;
			end else if (running_q) begin
				valid_q  <= 1'b1;
				result_q <= res_d;
				upc_q    <= uw.nxt;
				if (uw.last) begin
					running_q <= 1'b0;
				end
				unique case (uw.act)
					ACT_NONE: begin
					end
					ACT_START: begin
						saved_vaddr_q   <= item_q.vaddr[47:0];
						level_q         <= '0;
						awaiting_q      <= 1'b0;
						entry_address_q <= next_entry;
						if (item_q.opcode == OPC_MAP) begin
							saved_paddr_q <= item_q.paddr;
							saved_prot_q  <= item_q.prot;
							operation_q   <= OP_MAP;
						end else begin
							operation_q   <= OP_LOOKUP;
						end
					end
					ACT_DESCEND: begin
						level_q         <= level_q + 2'd1;
						awaiting_q      <= 1'b0;
						entry_address_q <= next_entry;
					end
					ACT_AWAIT: begin
						awaiting_q <= 1'b1;
					end
					ACT_IDLE: begin
						operation_q <= OP_IDLE;
						level_q     <= '0;
						awaiting_q  <= 1'b0;
					end
					default: begin
					end
				endcase
			end
		end
	end

endmodule

`default_nettype wire
